[sv/ldrd_pkg.sv]
// Shared types and constants for the length-prefixed request deframer.
package ldrd_pkg;

  // Every header field is a 32-bit little-endian value of four bytes.
  localparam logic [31:0] HDR_BYTES = 32'd4;

  // Result kinds.
  localparam logic [1:0] KIND_BYTE      = 2'd0;
  localparam logic [1:0] KIND_EMPTY     = 2'd1;
  localparam logic [1:0] KIND_NO_STRING = 2'd2;
  localparam logic [1:0] KIND_ERROR     = 2'd3;

  // Parser phases, one-hot.
  typedef enum logic [4:0] {
    PH_FLEN  = 5'b00001,
    PH_COUNT = 5'b00010,
    PH_SLEN  = 5'b00100,
    PH_DATA  = 5'b01000,
    PH_SKIP  = 5'b10000
  } phase_t;

  // One result as it travels through the result queue.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [31:0] string_index;
    logic        last_in_string;
    logic        last_in_frame;
    logic        frame_error;
  } res_t;

  localparam int RES_W = $bits(res_t);

endpackage

[sv/length_prefixed_request_deframer.sv]
// Request bytes are registered in the input queue, results in the result queue.
// Throughput: one byte per cycle if the result queue has room; single byte step.
// Input and result queues decouple both sides; the parser advances only with room.
// Reset: synchronous, active low; clears both queues and all parser state.
// After reset the parser waits for the first byte of a frame length.
module length_prefixed_request_deframer #(
  parameter int IN_DEPTH  = 2,
  parameter int OUT_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic [31:0] out_string_index,
  output logic        out_last_in_string,
  output logic        out_last_in_frame,
  output logic        out_frame_error
);
  import ldrd_pkg::*;

  logic       byte_empty;
  logic [7:0] byte_data;
  logic       byte_pop;
  logic       res_full;
  logic       res_push;
  res_t       res_in;
  res_t       res_out;

  // Front: request byte queue.
  ldrd_fifo #(
    .WIDTH (8),
    .DEPTH (IN_DEPTH)
  ) u_in_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (in_byte),
    .full  (in_full),
    .pop   (byte_pop),
    .rdata (byte_data),
    .empty (byte_empty)
  );

  // Back: frame parser.
  ldrd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (!byte_empty),
    .byte_data  (byte_data),
    .byte_pop   (byte_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res_data   (res_in)
  );

  // Result queue toward the consumer.
  ldrd_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_out),
    .empty (out_empty)
  );

  assign out_kind           = res_out.kind;
  assign out_data_byte      = res_out.data_byte;
  assign out_string_index   = res_out.string_index;
  assign out_last_in_string = res_out.last_in_string;
  assign out_last_in_frame  = res_out.last_in_frame;
  assign out_frame_error    = res_out.frame_error;

endmodule

[sv/ldrd_fifo.sv]
// Small first-word-fall-through queue built from registers.
module ldrd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset; only the entries between the pointers are read.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[sv/ldrd_parser.sv]
// Frame parser: walks headers and strings one byte per cycle while results have room.
module ldrd_parser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          byte_valid,
  input  logic [7:0]    byte_data,
  output logic          byte_pop,
  input  logic          res_full,
  output logic          res_push,
  output ldrd_pkg::res_t res_data
);
  import ldrd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  hbc_r, hbc_nxt;
  logic [31:0] hdr_shift_r, hdr_shift_nxt;
  logic [31:0] frame_left_r, frame_left_nxt;
  logic [31:0] strings_left_r, strings_left_nxt;
  logic [31:0] str_left_r, str_left_nxt;
  logic [31:0] cur_str_r, cur_str_nxt;

  logic        step;
  logic        emit;
  logic        do_close;
  logic        do_leave;
  logic        close_lif;
  logic        close_err;
  logic [31:0] hdr_value;
  logic        hdr_done;
  res_t        res;

  // A byte is taken only when the result queue has room for what it may cause.
  assign step     = byte_valid && !res_full;
  assign byte_pop = step;
  assign res_push = step && emit;
  assign res_data = res;

  always_comb begin
    phase_nxt        = phase_r;
    hbc_nxt          = hbc_r;
    hdr_shift_nxt    = hdr_shift_r;
    frame_left_nxt   = frame_left_r;
    strings_left_nxt = strings_left_r;
    str_left_nxt     = str_left_r;
    cur_str_nxt      = cur_str_r;
    emit             = 1'b0;
    do_close         = 1'b0;
    do_leave         = 1'b0;
    close_lif        = 1'b0;
    close_err        = 1'b0;
    res              = '0;
    hdr_value        = {byte_data, hdr_shift_r[31:8]};
    hdr_done         = (hbc_r == 2'd3);

    case (phase_r)
      // Skip the rest of a bad frame or its trailing bytes.
      PH_SKIP: begin
        if (frame_left_r != '0) begin
          frame_left_nxt = frame_left_r - 1'b1;
        end
        if (frame_left_nxt == '0) begin
          phase_nxt = PH_FLEN;
        end
      end

      // String body bytes.
      PH_DATA: begin
        if (frame_left_r != '0) begin
          frame_left_nxt = frame_left_r - 1'b1;
        end
        if (str_left_r != '0) begin
          str_left_nxt = str_left_r - 1'b1;
        end
        emit               = 1'b1;
        res.kind           = KIND_BYTE;
        res.data_byte      = byte_data;
        res.string_index   = cur_str_r;
        if (str_left_nxt == '0) begin
          do_close           = 1'b1;
          res.last_in_string = 1'b1;
        end
      end

      // Header phases; an invalid phase code acts as the frame-length header.
      default: begin
        if (phase_r != PH_FLEN && phase_r != PH_COUNT && phase_r != PH_SLEN) begin
          phase_nxt = PH_FLEN;
        end
        if ((phase_r == PH_COUNT || phase_r == PH_SLEN) && frame_left_r != '0) begin
          frame_left_nxt = frame_left_r - 1'b1;
        end
        hbc_nxt       = hbc_r + 1'b1;
        hdr_shift_nxt = hdr_value;
        if (hdr_done) begin
          hbc_nxt       = '0;
          hdr_shift_nxt = '0;
          if (phase_r == PH_COUNT) begin
            // String count complete.
            strings_left_nxt = hdr_value;
            cur_str_nxt      = '0;
            if (hdr_value == '0) begin
              emit              = 1'b1;
              res.kind          = KIND_NO_STRING;
              res.last_in_frame = 1'b1;
              do_leave          = 1'b1;
            end else if (frame_left_nxt < HDR_BYTES) begin
              emit            = 1'b1;
              res.kind        = KIND_ERROR;
              res.frame_error = 1'b1;
              do_leave        = 1'b1;
            end else begin
              phase_nxt = PH_SLEN;
            end
          end else if (phase_r == PH_SLEN) begin
            // String length complete.
            res.string_index = cur_str_r;
            if (hdr_value > frame_left_nxt) begin
              emit            = 1'b1;
              res.kind        = KIND_ERROR;
              res.frame_error = 1'b1;
              do_leave        = 1'b1;
            end else if (hdr_value == '0) begin
              emit               = 1'b1;
              res.kind           = KIND_EMPTY;
              res.last_in_string = 1'b1;
              do_close           = 1'b1;
            end else begin
              str_left_nxt = hdr_value;
              phase_nxt    = PH_DATA;
            end
          end else begin
            // Frame length complete.
            frame_left_nxt   = hdr_value;
            strings_left_nxt = '0;
            str_left_nxt     = '0;
            cur_str_nxt      = '0;
            if (hdr_value < HDR_BYTES) begin
              emit            = 1'b1;
              res.kind        = KIND_ERROR;
              res.frame_error = 1'b1;
              do_leave        = 1'b1;
            end else begin
              phase_nxt = PH_COUNT;
            end
          end
        end
      end
    endcase

    // Closing a string: end the frame, flag a missing header, or expect the next one.
    if (do_close) begin
      if (strings_left_r != '0) begin
        strings_left_nxt = strings_left_r - 1'b1;
      end
      if (strings_left_nxt == '0) begin
        close_lif = 1'b1;
        do_leave  = 1'b1;
      end else begin
        cur_str_nxt = cur_str_r + 1'b1;
        if (frame_left_nxt < HDR_BYTES) begin
          close_err = 1'b1;
          do_leave  = 1'b1;
        end else begin
          hbc_nxt       = '0;
          hdr_shift_nxt = '0;
          phase_nxt     = PH_SLEN;
        end
      end
      res.last_in_frame = close_lif;
      res.frame_error   = close_err;
    end

    // Leaving a frame: skip what remains of it or start the next header.
    if (do_leave) begin
      hbc_nxt       = '0;
      hdr_shift_nxt = '0;
      phase_nxt     = (frame_left_nxt != '0) ? PH_SKIP : PH_FLEN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_FLEN;
      hbc_r          <= '0;
      hdr_shift_r    <= '0;
      frame_left_r   <= '0;
      strings_left_r <= '0;
      str_left_r     <= '0;
      cur_str_r      <= '0;
    end else if (step) begin
      phase_r        <= phase_nxt;
      hbc_r          <= hbc_nxt;
      hdr_shift_r    <= hdr_shift_nxt;
      frame_left_r   <= frame_left_nxt;
      strings_left_r <= strings_left_nxt;
      str_left_r     <= str_left_nxt;
      cur_str_r      <= cur_str_nxt;
    end
  end

endmodule

[sv/ldrd_checker.sv]
// Port-level checks for the deframer, bound to the top level.
module ldrd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_full,
  input logic        out_empty,
  input logic        out_pop,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_data_byte,
  input logic [31:0] out_string_index,
  input logic        out_last_in_string,
  input logic        out_last_in_frame,
  input logic        out_frame_error
);
  import ldrd_pkg::*;

  // Reset leaves both queues empty.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // A frame without strings is a clean end of frame at index zero.
  a_no_string: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_kind == KIND_NO_STRING) |->
      out_last_in_frame && !out_frame_error && !out_last_in_string &&
      out_string_index == '0 && out_data_byte == '0)
    else $error("malformed no-string request");

  // An error-only result carries the error flag and no data or end marks.
  a_error_only: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_kind == KIND_ERROR) |->
      out_frame_error && !out_last_in_string && !out_last_in_frame &&
      out_data_byte == '0)
    else $error("malformed error request");

  // An empty, error or frame-end string result always closes its string.
  a_frame_end_string: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_kind == KIND_BYTE || out_kind == KIND_EMPTY) &&
     (out_last_in_frame || out_frame_error || out_kind == KIND_EMPTY)) |->
      out_last_in_string)
    else $error("frame end without string end");

  // A waiting result holds until it is popped.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      !out_empty && $stable(out_kind) && $stable(out_data_byte) &&
      $stable(out_string_index) && $stable(out_last_in_string) &&
      $stable(out_last_in_frame) && $stable(out_frame_error))
    else $error("result changed while stalled");

endmodule

bind length_prefixed_request_deframer ldrd_checker u_ldrd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_full            (in_full),
  .out_empty          (out_empty),
  .out_pop            (out_pop),
  .out_kind           (out_kind),
  .out_data_byte      (out_data_byte),
  .out_string_index   (out_string_index),
  .out_last_in_string (out_last_in_string),
  .out_last_in_frame  (out_last_in_frame),
  .out_frame_error    (out_frame_error)
);

[dv/tb_length_prefixed_request_deframer.sv]
// Self-checking testbench for the length-prefixed request deframer.
module tb_length_prefixed_request_deframer;
  timeunit 1ns;
  timeprecision 1ps;
  import ldrd_pkg::*;

  localparam int RANDOM_BYTES   = 1950;
  localparam int PAUSE_AT_BYTES = 1000;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;

  // One row of the directed table: a request byte and, where obvious, its result.
  typedef struct packed {
    logic [7:0] req_byte;
    logic       typed;
    res_t       res;
  } stim_row_t;

  typedef enum int {FLAW_NONE, FLAW_SHORT, FLAW_TRUNCATE, FLAW_BAD_LENGTH, FLAW_COUNT}
    frame_flaw_t;
  typedef enum int {POP_ALWAYS, POP_PATTERN, POP_SPARSE} pop_mode_t;

  localparam res_t NO_RES = '0;
  localparam res_t RES_SHORT_FRAME = '{kind: KIND_ERROR, data_byte: 8'h00,
      string_index: 32'd0, last_in_string: 1'b0, last_in_frame: 1'b0, frame_error: 1'b1};
  localparam res_t RES_NO_STRINGS = '{kind: KIND_NO_STRING, data_byte: 8'h00,
      string_index: 32'd0, last_in_string: 1'b0, last_in_frame: 1'b1, frame_error: 1'b0};
  localparam res_t RES_ONE_BYTE = '{kind: KIND_BYTE, data_byte: 8'hff,
      string_index: 32'd0, last_in_string: 1'b1, last_in_frame: 1'b1, frame_error: 1'b0};

  // Directed frames: zero length, no strings, and one string of a single byte.
  localparam stim_row_t DIR_TABLE [25] = '{
    '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b1, RES_SHORT_FRAME},
    '{8'h04, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b1, RES_NO_STRINGS},
    '{8'h09, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES}, '{8'h01, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h01, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
    '{8'hff, 1'b1, RES_ONE_BYTE}
  };

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [7:0]  in_byte;
  logic        out_empty;
  logic        out_pop;
  logic [1:0]  out_kind;
  logic [7:0]  out_data_byte;
  logic [31:0] out_string_index;
  logic        out_last_in_string;
  logic        out_last_in_frame;
  logic        out_frame_error;

  // Side information that travels with the request byte being offered.
  logic        row_typed;
  res_t        row_res;

  // Parser state mirrored by the predictor.
  phase_t      st_phase;
  logic [1:0]  hdr_cnt;
  logic [31:0] hdr_acc;
  logic [31:0] frame_left;
  logic [31:0] strings_rem;
  logic [31:0] body_left;
  logic [31:0] str_idx;

  res_t        deframed_q[$];
  logic [7:0]  req_bytes[$];
  int          mismatches;
  int          idle_cycles;
  bit          byte_taken;
  bit          draining;
  int          burst_left;

  // Monitor variables.
  bit          in_acc;
  bit          out_acc;
  bit          pred_valid;
  res_t        pred_res;
  res_t        want;
  res_t        seen;

  // Receiver pattern state.
  pop_mode_t   pop_mode;
  logic [31:0] pop_bits;
  int          pop_left;
  logic [4:0]  pop_phase;
  logic        pop_next;

  length_prefixed_request_deframer DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_byte            (in_byte),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_kind           (out_kind),
    .out_data_byte      (out_data_byte),
    .out_string_index   (out_string_index),
    .out_last_in_string (out_last_in_string),
    .out_last_in_frame  (out_last_in_frame),
    .out_frame_error    (out_frame_error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The frame is finished: skip what remains of it, or wait for the next length.
  task automatic leave_frame();
    hdr_cnt = '0;
    hdr_acc = '0;
    st_phase = (frame_left != 0) ? PH_SKIP : PH_FLEN;
  endtask

  // A string is complete; moves on to the next string header or out of the frame.
  task automatic end_string(output logic lif, output logic err);
    lif = 1'b0;
    err = 1'b0;
    if (strings_rem != 0) strings_rem--;
    if (strings_rem == 0) begin
      lif = 1'b1;
      leave_frame();
    end else begin
      str_idx++;
      if (frame_left < HDR_BYTES) begin
        err = 1'b1;
        leave_frame();
      end else begin
        hdr_cnt = '0;
        hdr_acc = '0;
        st_phase = PH_SLEN;
      end
    end
  endtask

  // Advances the parser by one request byte and gives the result it causes, if any.
  task automatic parse_request_byte(input logic [7:0] b, output bit got, output res_t r);
    logic [31:0] value;
    logic [31:0] idx;
    logic        lif;
    logic        err;
    bit          done;
    got = 1'b0;
    r = '0;
    if (st_phase == PH_SKIP) begin
      if (frame_left != 0) frame_left--;
      if (frame_left == 0) st_phase = PH_FLEN;
    end else if (st_phase == PH_DATA) begin
      if (frame_left != 0) frame_left--;
      if (body_left != 0) body_left--;
      idx = str_idx;
      got = 1'b1;
      if (body_left != 0) begin
        r = '{KIND_BYTE, b, idx, 1'b0, 1'b0, 1'b0};
      end else begin
        end_string(lif, err);
        r = '{KIND_BYTE, b, idx, 1'b1, lif, err};
      end
    end else begin
      if (st_phase != PH_COUNT && st_phase != PH_SLEN) st_phase = PH_FLEN;
      if (st_phase != PH_FLEN && frame_left != 0) frame_left--;
      hdr_acc = {b, hdr_acc[31:8]};
      done = (hdr_cnt == 2'd3);
      hdr_cnt = hdr_cnt + 2'd1;
      if (done) begin
        value = hdr_acc;
        hdr_acc = '0;
        hdr_cnt = '0;
        if (st_phase == PH_FLEN) begin
          frame_left = value;
          strings_rem = '0;
          body_left = '0;
          str_idx = '0;
          if (value < HDR_BYTES) begin
            got = 1'b1;
            r = '{KIND_ERROR, 8'h00, 32'd0, 1'b0, 1'b0, 1'b1};
            leave_frame();
          end else begin
            st_phase = PH_COUNT;
          end
        end else if (st_phase == PH_COUNT) begin
          strings_rem = value;
          str_idx = '0;
          if (value == 0) begin
            got = 1'b1;
            r = '{KIND_NO_STRING, 8'h00, 32'd0, 1'b0, 1'b1, 1'b0};
            leave_frame();
          end else if (frame_left < HDR_BYTES) begin
            got = 1'b1;
            r = '{KIND_ERROR, 8'h00, 32'd0, 1'b0, 1'b0, 1'b1};
            leave_frame();
          end else begin
            st_phase = PH_SLEN;
          end
        end else begin
          idx = str_idx;
          if (value > frame_left) begin
            got = 1'b1;
            r = '{KIND_ERROR, 8'h00, idx, 1'b0, 1'b0, 1'b1};
            leave_frame();
          end else if (value == 0) begin
            end_string(lif, err);
            got = 1'b1;
            r = '{KIND_EMPTY, 8'h00, idx, 1'b1, lif, err};
          end else begin
            body_left = value;
            st_phase = PH_DATA;
          end
        end
      end
    end
  endtask

  task automatic report_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
    mismatches++;
  endtask

  // Sample both handshakes, predict accepted requests and check popped results.
  always @(posedge clk) begin
    if (rst_n) begin
      in_acc = in_push && !in_full;
      out_acc = out_pop && !out_empty;
      byte_taken = in_acc;
      if (out_acc) begin
        seen = '{out_kind, out_data_byte, out_string_index, out_last_in_string,
                 out_last_in_frame, out_frame_error};
        if (deframed_q.size() == 0) begin
          $display("%0t: result with none expected, expected nothing, actual 0x%0h",
                   $time, seen);
          mismatches++;
        end else begin
          want = deframed_q.pop_front();
          if (seen.kind != want.kind)
            report_field("kind", 32'(want.kind), 32'(seen.kind));
          if (seen.data_byte != want.data_byte)
            report_field("data_byte", 32'(want.data_byte), 32'(seen.data_byte));
          if (seen.string_index != want.string_index)
            report_field("string_index", want.string_index, seen.string_index);
          if (seen.last_in_string != want.last_in_string)
            report_field("last_in_string", 32'(want.last_in_string),
                         32'(seen.last_in_string));
          if (seen.last_in_frame != want.last_in_frame)
            report_field("last_in_frame", 32'(want.last_in_frame),
                         32'(seen.last_in_frame));
          if (seen.frame_error != want.frame_error)
            report_field("frame_error", 32'(want.frame_error), 32'(seen.frame_error));
        end
      end
      if (in_acc) begin
        parse_request_byte(in_byte, pred_valid, pred_res);
        if (pred_valid) deframed_q.push_back(row_typed ? row_res : pred_res);
      end
      // Watchdog on cycles in which neither side moves a request or a result.
      if (in_acc || out_acc) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  // Receiver: switches between always popping, a bit pattern, and sparse pops.
  always @(negedge clk) begin
    if (pop_left == 0) begin
      case ($urandom_range(0, 3))
        0: pop_mode = POP_ALWAYS;
        1: pop_mode = POP_SPARSE;
        default: pop_mode = POP_PATTERN;
      endcase
      pop_bits = $urandom;
      pop_left = $urandom_range(16, 128);
    end
    pop_left--;
    pop_phase++;
    case (pop_mode)
      POP_ALWAYS: pop_next = 1'b1;
      POP_SPARSE: pop_next = ($urandom_range(0, 3) == 0);
      default:    pop_next = pop_bits[pop_phase];
    endcase
    out_pop <= pop_next || draining;
  end

  task automatic add_word(ref logic [7:0] q[$], input logic [31:0] v);
    q.push_back(v[7:0]);
    q.push_back(v[15:8]);
    q.push_back(v[23:16]);
    q.push_back(v[31:24]);
  endtask

  // Builds one random frame, mostly well formed, into the request byte queue.
  task automatic queue_frame();
    logic [7:0]  body[$];
    frame_flaw_t flaw;
    int unsigned n;
    int unsigned bad;
    int unsigned len;
    int unsigned keep;
    logic [31:0] cnt;
    case ($urandom_range(0, 19))
      13:      flaw = FLAW_SHORT;
      14, 15:  flaw = FLAW_TRUNCATE;
      16, 17:  flaw = FLAW_BAD_LENGTH;
      18, 19:  flaw = FLAW_COUNT;
      default: flaw = FLAW_NONE;
    endcase
    if (flaw == FLAW_SHORT) begin
      repeat ($urandom_range(0, 3)) body.push_back(8'($urandom_range(0, 255)));
    end else begin
      case ($urandom_range(0, 9))
        0:       n = 0;
        8, 9:    n = $urandom_range(4, 6);
        default: n = $urandom_range(1, 3);
      endcase
      bad = (flaw == FLAW_BAD_LENGTH && n > 0) ? $urandom_range(0, n - 1) : n;
      cnt = n;
      if (flaw == FLAW_COUNT) cnt = $urandom_range(0, 1) ? $urandom : n + $urandom_range(1, 2);
      add_word(body, cnt);
      for (int k = 0; k < n; k++) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 6);
        // A length beyond anything left in the frame forces an overrun.
        add_word(body, (k == bad) ? ($urandom | 32'h0000_1000) : len);
        repeat (len) body.push_back(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 5)) body.push_back(8'($urandom));
      if (flaw == FLAW_TRUNCATE) begin
        keep = $urandom_range(0, body.size() - 1);
        while (body.size() > keep) void'(body.pop_back());
      end
    end
    add_word(req_bytes, body.size());
    foreach (body[i]) req_bytes.push_back(body[i]);
  endtask

  // Offers one request byte and holds it until accepted; bursts with random gaps.
  task automatic send_request(input logic [7:0] b, input logic typed, input res_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if ($urandom_range(0, 15) == 0) gap = $urandom_range(20, 40);
      if (gap > 0) begin
        in_push <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_push   <= 1'b1;
    in_byte   <= b;
    row_typed <= typed;
    row_res   <= r;
    do @(negedge clk); while (!byte_taken);
  endtask

  // Holds the sender until every expected result has been popped.
  task automatic wait_for_results();
    in_push <= 1'b0;
    do @(negedge clk); while (deframed_q.size() != 0);
  endtask

  initial begin
    int sent;
    bit paused;
    rst_n       = 1'b0;
    in_push     = 1'b0;
    in_byte     = 8'h00;
    out_pop     = 1'b0;
    row_typed   = 1'b0;
    row_res     = NO_RES;
    draining    = 1'b0;
    burst_left  = 0;
    pop_left    = 0;
    pop_phase   = '0;
    mismatches  = 0;
    idle_cycles = 0;
    byte_taken  = 1'b0;
    st_phase    = PH_FLEN;
    hdr_cnt     = '0;
    hdr_acc     = '0;
    frame_left  = '0;
    strings_rem = '0;
    body_left   = '0;
    str_idx     = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed frames first.
    foreach (DIR_TABLE[i]) send_request(DIR_TABLE[i].req_byte, DIR_TABLE[i].typed,
                                        DIR_TABLE[i].res);
    wait_for_results();

    // Random frames, with one full pause partway through.
    sent = 0;
    paused = 1'b0;
    while (sent < RANDOM_BYTES) begin
      queue_frame();
      while (req_bytes.size() != 0) begin
        send_request(req_bytes.pop_front(), 1'b0, NO_RES);
        sent++;
      end
      if (!paused && sent >= PAUSE_AT_BYTES) begin
        wait_for_results();
        paused = 1'b1;
      end
    end

    // Drain with the receiver always ready, then allow for late extra results.
    in_push <= 1'b0;
    draining = 1'b1;
    while (deframed_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
